// ===== rtl/ntc_pkg.sv =====
// Types and constants shared by the nearest-template classifier modules.
package ntc_pkg;

  localparam int SLOT_BITS    = 4;
  localparam int POS_BITS     = 6;
  localparam int FEATURE_BITS = 16;
  localparam int CNT_BITS     = 5;
  localparam int DIST_BITS    = 38;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [SLOT_BITS-1:0]    template_slot;
    logic [POS_BITS-1:0]     feature_pos;
    logic [FEATURE_BITS-1:0] feature_value;
    logic                    last_feature;
  } req_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] best_slot;
    logic                 found;
    logic [DIST_BITS-1:0] best_distance;
  } rsp_t;

  // Control that travels with one template step of a query pass
  typedef struct packed {
    logic                vld;
    logic [CNT_BITS-1:0] slot;
    logic                last;
    logic                pos_ok;
    logic                first;
    logic                tail;
  } pass_ctl_t;

  // Accumulator write-back
  typedef struct packed {
    logic                 en;
    logic [CNT_BITS-1:0]  slot;
    logic [DIST_BITS-1:0] data;
  } acc_wr_t;

  // Search result at the end of a last-marked pass
  typedef struct packed {
    logic                 vld;
    logic [CNT_BITS-1:0]  slot;
    logic [DIST_BITS-1:0] distance;
  } res_t;

endpackage

// ===== rtl/ntc_tmpl_mem.sv =====
// Template feature store: one write port, one registered read port.
module ntc_tmpl_mem import ntc_pkg::*; #(
  parameter int VALUE_BITS = 16,
  parameter int DEPTH      = 640,
  parameter int AW         = 10
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [VALUE_BITS-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [VALUE_BITS-1:0] rdata
);

  logic [VALUE_BITS-1:0] mem [DEPTH];

  // Write one feature word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ntc_acc_mem.sv =====
// Distance accumulator store with per-entry valid bits; an invalid entry reads as zero.
module ntc_acc_mem import ntc_pkg::*; #(
  parameter int TEMPLATES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 rd_en,
  input  logic [CNT_BITS-1:0]  rd_slot,
  output logic [DIST_BITS-1:0] rd_data,
  input  acc_wr_t              wr
);

  localparam int TW = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;

  logic [DIST_BITS-1:0] mem [TEMPLATES];
  logic [TEMPLATES-1:0] valid;
  logic [DIST_BITS-1:0] rdata_q;
  logic                 rhit_q;

  // Data array write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[TW'(wr.slot)] <= wr.data;
    end
  end

  // Valid bits: clear wins over a write
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[TW'(wr.slot)] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_q <= mem[TW'(rd_slot)];
      rhit_q  <= valid[TW'(rd_slot)];
    end
  end

  assign rd_data = rhit_q ? rdata_q : '0;

endmodule

// ===== rtl/ntc_dist_unit.sv =====
// Shared squared-difference unit: square, saturating accumulate, running minimum.
module ntc_dist_unit import ntc_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pass_ctl_t             ctl_in,
  input  logic [VALUE_BITS-1:0] tmpl,
  input  logic [VALUE_BITS-1:0] qval,
  input  logic [DIST_BITS-1:0]  acc,
  output acc_wr_t               acc_wr,
  output res_t                  res,
  output logic                  busy
);

  localparam int PW = 2 * VALUE_BITS;
  localparam int SW = ((PW > DIST_BITS) ? PW : DIST_BITS) + 1;

  pass_ctl_t             ctl2;
  logic [PW-1:0]         prod2;
  logic [DIST_BITS-1:0]  acc2;
  logic [VALUE_BITS-1:0] diff;
  logic [PW-1:0]         prod_next;
  logic [SW-1:0]         sum_w;
  logic [DIST_BITS-1:0]  sum_sat;
  logic                  better;
  logic [DIST_BITS-1:0]  best_d;
  logic [CNT_BITS-1:0]   best_slot;

  // Stage 1: absolute difference and square
  always_comb begin
    diff      = (tmpl >= qval) ? (tmpl - qval) : (qval - tmpl);
    prod_next = ctl_in.pos_ok ? (PW'(diff) * PW'(diff)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else begin
      ctl2 <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    prod2 <= prod_next;
    acc2  <= acc;
  end

  // Stage 2: saturating add and compare against the running best
  always_comb begin
    sum_w   = SW'(acc2) + SW'(prod2);
    sum_sat = (sum_w > SW'(DIST_MAX)) ? DIST_MAX : sum_w[DIST_BITS-1:0];
    better  = ctl2.first || (sum_sat < best_d);
  end

  // Hold the best so far across a last-marked pass
  always_ff @(posedge clk) begin
    if (ctl2.vld && ctl2.last && better) begin
      best_d    <= sum_sat;
      best_slot <= ctl2.slot;
    end
  end

  // Write back only on passes that do not end the query
  always_comb begin
    acc_wr.en    = ctl2.vld && !ctl2.last && ctl2.pos_ok;
    acc_wr.slot  = ctl2.slot;
    acc_wr.data  = sum_sat;
    res.vld      = ctl2.vld && ctl2.last && ctl2.tail;
    res.slot     = better ? ctl2.slot : best_slot;
    res.distance = better ? sum_sat : best_d;
  end

  assign busy = ctl2.vld;

endmodule

// ===== rtl/nearest_template_classifier.sv =====
// Top level: request sequencer, template and accumulator stores, result buffer.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_t (load or query feature)
//  rsp      out        rsp_valid / rsp_stall  rsp_t (nearest slot, distance)
//  cfg      in         cfg_valid / cfg_ready  templates_in_use, 5 bits
//
// A load beat writes the template store directly. A query beat walks the n
// clamped templates, one per cycle, through the shared square-and-accumulate
// unit after its accept cycle; the memory read and the add are registered.
// With no templates no pass starts; a last-marked beat gives an empty result.
// Reset (rst, synchronous) clears the count, the accumulators and the result
// buffer; the template store keeps no reset state. A finished result waits in
// a holding register, and input stalls while that register is full, which
// lasts longer while rsp_stall keeps the output full.
module nearest_template_classifier import ntc_pkg::*; #(
  parameter int TEMPLATES  = 16,
  parameter int FEATURES   = 40,
  parameter int VALUE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  req_t                req,
  input  logic                req_valid,
  output logic                req_stall,
  output rsp_t                rsp,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  logic [CNT_BITS-1:0] cfg_data,
  input  logic                cfg_valid,
  output logic                cfg_ready
);

  localparam int DEPTH = TEMPLATES * FEATURES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VB_IN = (VALUE_BITS < FEATURE_BITS) ? VALUE_BITS : FEATURE_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                  state;
  logic [CNT_BITS-1:0]   templates_in_use;
  logic [CNT_BITS-1:0]   n_eff;
  logic [CNT_BITS-1:0]   t;
  logic [AW-1:0]         base;
  logic [VALUE_BITS-1:0] q_val;
  logic                  q_last;
  logic                  q_pos_ok;
  pass_ctl_t             s0;
  pass_ctl_t             s1;
  logic                  pend_valid;
  rsp_t                  pend;
  logic                  accept;
  logic                  pos_ok_in;
  logic                  slot_ok_in;
  logic [VALUE_BITS-1:0] val_in;
  logic                  tm_we;
  logic [AW-1:0]         tm_waddr;
  logic [VALUE_BITS-1:0] tm_rdata;
  logic [DIST_BITS-1:0]  acc_rdata;
  acc_wr_t               acc_wr;
  res_t                  res;
  logic                  dist_busy;
  logic                  empty_last;
  logic                  acc_clear;
  logic                  rsp_load;

  // Clamp the template count to the store size
  assign n_eff = (32'(templates_in_use) > TEMPLATES) ? CNT_BITS'(TEMPLATES) : templates_in_use;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE) || s1.vld || dist_busy || pend_valid;
  assign accept    = req_valid && !req_stall;

  // Decode the incoming beat
  always_comb begin
    pos_ok_in  = 32'(req.feature_pos) < FEATURES;
    slot_ok_in = 32'(req.template_slot) < TEMPLATES;
    val_in     = VALUE_BITS'(req.feature_value[VB_IN-1:0]);
    tm_we      = accept && (req.req_type == REQ_LOAD) && slot_ok_in && pos_ok_in;
    tm_waddr   = AW'(32'(req.template_slot) * FEATURES + 32'(req.feature_pos));
    empty_last = accept && (req.req_type == REQ_QUERY) && req.last_feature && (n_eff == '0);
    acc_clear  = res.vld || empty_last;
  end

  // Issue one template step per cycle while running
  always_comb begin
    s0.vld    = (state == ST_RUN);
    s0.slot   = t;
    s0.last   = q_last;
    s0.pos_ok = q_pos_ok;
    s0.first  = (t == '0);
    s0.tail   = (t == n_eff - CNT_BITS'(1));
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      templates_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      templates_in_use <= cfg_data;
    end
  end

  // Sequencer: start a pass on a query beat, walk the templates
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && (req.req_type == REQ_QUERY) && (n_eff != '0)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (s0.tail) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Query item and template walk registers
  always_ff @(posedge clk) begin
    if (accept && (req.req_type == REQ_QUERY)) begin
      q_val    <= val_in;
      q_last   <= req.last_feature;
      q_pos_ok <= pos_ok_in;
      t        <= '0;
      base     <= AW'(req.feature_pos);
    end else if (state == ST_RUN) begin
      t    <= t + CNT_BITS'(1);
      base <= base + AW'(FEATURES);
    end
  end

  // Align control with the memory read latency
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= s0;
    end
  end

  ntc_tmpl_mem #(
    .VALUE_BITS (VALUE_BITS),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_tmpl_mem (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (val_in),
    .re    (s0.vld && q_pos_ok),
    .raddr (base),
    .rdata (tm_rdata)
  );

  ntc_acc_mem #(
    .TEMPLATES (TEMPLATES)
  ) u_acc_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (acc_clear),
    .rd_en   (s0.vld),
    .rd_slot (s0.slot),
    .rd_data (acc_rdata),
    .wr      (acc_wr)
  );

  ntc_dist_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dist_unit (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (s1),
    .tmpl   (tm_rdata),
    .qval   (q_val),
    .acc    (acc_rdata),
    .acc_wr (acc_wr),
    .res    (res),
    .busy   (dist_busy)
  );

  // Holding register for a finished result
  assign rsp_load = pend_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (res.vld || empty_last) begin
      pend_valid <= 1'b1;
    end else if (rsp_load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      pend.best_slot     <= res.slot[SLOT_BITS-1:0];
      pend.found         <= 1'b1;
      pend.best_distance <= res.distance;
    end else if (empty_last) begin
      pend <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= pend;
    end
  end

`ifndef SYNTHESIS
  a_res_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.vld |-> !pend_valid)
    else $error("result finished while holding register full");

  a_acc_no_collision: assert property (@(posedge clk) disable iff (rst)
    !(acc_wr.en && s0.vld && (acc_wr.slot == s0.slot)))
    else $error("accumulator read and write-back hit the same slot");

  a_rsp_from_pend: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(pend_valid))
    else $error("output beat raised without a held result");

  a_run_needs_count: assert property (@(posedge clk) disable iff (rst)
    s0.vld |-> (n_eff != '0))
    else $error("pass running with no templates in use");
`endif

endmodule
